// File: rtl/isb_pkg.sv
// isb_pkg: shared types and codes for the indexed sequence buffer
// used by isb_cell and indexed_sequence_buffer, no dependencies
package isb_pkg;

  localparam int OP_BITS     = 3;
  localparam int INDEX_BITS  = 6;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 7;

  localparam int IN_BITS   = OP_BITS + INDEX_BITS + VALUE_BITS;
  localparam int OUT_BITS  = VALUE_BITS + STATUS_BITS + COUNT_BITS;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_ERASE  = 3'd4,
    OP_INSERT = 3'd5
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_ERASE  = 2'd2,
    CELL_INSERT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tap_load;
    logic     tap_shift;
  } cell_ctrl_t;

endpackage

// File: rtl/isb_cell.sv
// isb_cell: one storage cell of the sequence row, element plus read-out tap
// depends on isb_pkg for the cell control struct
module isb_cell #(
  parameter int ELEM_BITS = 32,
  parameter int IDX_W     = 6
) (
  input  logic                    clk,
  input  isb_pkg::cell_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]        pos,
  input  logic [IDX_W-1:0]        sel,
  input  logic [ELEM_BITS-1:0]    wdata,
  input  logic [ELEM_BITS-1:0]    left_data,
  input  logic [ELEM_BITS-1:0]    right_data,
  input  logic [ELEM_BITS-1:0]    right_tap,
  output logic [ELEM_BITS-1:0]    data,
  output logic [ELEM_BITS-1:0]    tap
);

  logic [ELEM_BITS-1:0] data_next;
  logic [ELEM_BITS-1:0] tap_next;

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      isb_pkg::CELL_HOLD: begin
        data_next = data;
      end
      isb_pkg::CELL_WRITE: begin
        if (pos == sel) data_next = wdata;
      end
      isb_pkg::CELL_ERASE: begin
        if (pos >= sel) data_next = right_data;
      end
      isb_pkg::CELL_INSERT: begin
        if (pos > sel) data_next = left_data;
        else if (pos == sel) data_next = wdata;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_comb begin
    tap_next = tap;
    if (ctrl.tap_load) tap_next = data;
    else if (ctrl.tap_shift) tap_next = right_tap;
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    tap  <= tap_next;
  end

endmodule

// File: rtl/indexed_sequence_buffer.sv
// indexed_sequence_buffer: ordered sequence with append, pop, get, set, erase, insert
// depends on isb_pkg and isb_cell
//
// usage
//   s_* channel takes one command per transfer, m_* channel returns one result per
//   command, in order. s_tready is high when no read is in progress and the output
//   register is empty or being taken in the same cycle.
//   append, set, erase, insert, the unused opcodes and every rejected command finish
//   without a read-out: the result is valid the cycle after the transfer, so these
//   run at one per cycle while the receiver keeps m_tready high.
//   get and a successful pop copy the whole row into the tap chain, which then moves
//   one cell towards position zero per cycle; the result is registered once the
//   indexed element reaches position zero (for pop the index is count - 1), and no
//   command is taken meanwhile.
//   erase and insert move every cell at or beyond the index to its neighbour in
//   parallel.
//   reset empties the sequence and drops any pending result; element contents are
//   not cleared.
//   while the receiver stalls the result is held in the output register and
//   s_tready stays low.
module indexed_sequence_buffer #(
  parameter int DEPTH     = 64,
  parameter int ELEM_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // operation[2:0], index[8:3], value[40:9], zero fill
  input  logic [isb_pkg::IN_TDATA-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // read_value[31:0], status[33:32], count[40:34], zero fill
  output logic [isb_pkg::OUT_TDATA-1:0]  m_tdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > isb_pkg::INDEX_BITS) ? CNT_W : isb_pkg::INDEX_BITS;
  localparam int VB    = isb_pkg::VALUE_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  rd_cnt, rd_cnt_next;
  logic [VB-1:0]     out_value, out_value_next;
  logic [isb_pkg::STATUS_BITS-1:0] out_status, out_status_next;
  logic [isb_pkg::COUNT_BITS-1:0]  out_count, out_count_next;
  logic              m_valid_next;

  logic [isb_pkg::OP_BITS-1:0]    in_op;
  logic [isb_pkg::INDEX_BITS-1:0] in_index;
  logic [VB-1:0]                  in_value;
  logic [ELEM_BITS+VB-1:0]        wdata_ext;
  logic [ELEM_BITS-1:0]           wdata;
  logic [ELEM_BITS+VB-1:0]        rdata_ext;

  logic              accept;
  logic              start_read;
  logic              finish_read;
  logic              full;
  logic [CMP_W-1:0]  idx_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [CNT_W-1:0]  cnt_less;
  logic [IDX_W-1:0]  sel;
  isb_pkg::status_t  status;
  isb_pkg::cell_ctrl_t ctrl;

  logic [ELEM_BITS-1:0] cell_data [DEPTH];
  logic [ELEM_BITS-1:0] cell_tap  [DEPTH];

  assign in_op     = s_tdata[isb_pkg::OP_BITS-1:0];
  assign in_index  = s_tdata[isb_pkg::OP_BITS +: isb_pkg::INDEX_BITS];
  assign in_value  = s_tdata[isb_pkg::OP_BITS + isb_pkg::INDEX_BITS +: VB];
  assign wdata_ext = {{ELEM_BITS{1'b0}}, in_value};
  assign wdata     = wdata_ext[ELEM_BITS-1:0];
  assign rdata_ext = {{VB{1'b0}}, cell_tap[0]};

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));
  assign idx_c    = CMP_W'(in_index);
  assign cnt_c    = CMP_W'(count);
  assign cnt_less = count - CNT_W'(1);
  assign finish_read = (state == S_READ) && (rd_cnt == '0);

  // command decode
  always_comb begin
    ctrl       = '{op: isb_pkg::CELL_HOLD, tap_load: 1'b0, tap_shift: 1'b0};
    sel        = idx_c[IDX_W-1:0];
    status     = isb_pkg::STAT_OK;
    count_next = count;
    start_read = 1'b0;
    unique case (in_op)
      isb_pkg::OP_APPEND: begin
        sel = count[IDX_W-1:0];
        if (full) begin
          status = isb_pkg::STAT_FULL;
        end else begin
          ctrl.op    = isb_pkg::CELL_WRITE;
          count_next = count + CNT_W'(1);
        end
      end
      isb_pkg::OP_POP: begin
        sel = cnt_less[IDX_W-1:0];
        if (count == '0) begin
          status = isb_pkg::STAT_RANGE;
        end else begin
          start_read = 1'b1;
          count_next = cnt_less;
        end
      end
      isb_pkg::OP_GET: begin
        if (idx_c >= cnt_c) status = isb_pkg::STAT_RANGE;
        else start_read = 1'b1;
      end
      isb_pkg::OP_SET: begin
        if (idx_c >= cnt_c) status = isb_pkg::STAT_RANGE;
        else ctrl.op = isb_pkg::CELL_WRITE;
      end
      isb_pkg::OP_ERASE: begin
        if (idx_c >= cnt_c) begin
          status = isb_pkg::STAT_RANGE;
        end else begin
          ctrl.op    = isb_pkg::CELL_ERASE;
          count_next = cnt_less;
        end
      end
      isb_pkg::OP_INSERT: begin
        if (idx_c > cnt_c) begin
          status = isb_pkg::STAT_RANGE;
        end else if (full) begin
          status = isb_pkg::STAT_FULL;
        end else begin
          ctrl.op    = isb_pkg::CELL_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      default: begin
        status = isb_pkg::STAT_OK;
      end
    endcase
    if (!accept) begin
      ctrl.op    = isb_pkg::CELL_HOLD;
      count_next = count;
      start_read = 1'b0;
    end
    ctrl.tap_load  = start_read;
    ctrl.tap_shift = (state == S_READ) && (rd_cnt != '0);
  end

  // control and result register
  always_comb begin
    state_next      = state;
    rd_cnt_next     = rd_cnt;
    out_value_next  = out_value;
    out_status_next = out_status;
    out_count_next  = out_count;
    m_valid_next    = m_tvalid && !m_tready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          out_status_next = status;
          out_count_next  = isb_pkg::COUNT_BITS'(count_next);
          out_value_next  = '0;
          if (start_read) begin
            state_next  = S_READ;
            rd_cnt_next = sel;
          end else begin
            m_valid_next = 1'b1;
          end
        end
      end
      S_READ: begin
        if (finish_read) begin
          state_next     = S_IDLE;
          out_value_next = rdata_ext[VB-1:0];
          m_valid_next   = 1'b1;
        end else begin
          rd_cnt_next = rd_cnt - IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      m_tvalid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt     <= rd_cnt_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
    out_count  <= out_count_next;
  end

  assign m_tdata = isb_pkg::OUT_TDATA'({out_count, out_status, out_value});

  // row of cells, neighbours linked both ways
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_BITS-1:0] left_d;
    logic [ELEM_BITS-1:0] right_d;
    logic [ELEM_BITS-1:0] right_t;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
      assign right_t = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
      assign right_t = cell_tap[i+1];
    end

    isb_cell #(
      .ELEM_BITS (ELEM_BITS),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (IDX_W'(i)),
      .sel        (sel),
      .wdata      (wdata),
      .left_data  (left_d),
      .right_data (right_d),
      .right_tap  (right_t),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stored count above capacity");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !s_tready)
    else $error("transfer accepted during read-out");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    finish_read |=> m_tvalid)
    else $error("read-out finished without a result");

  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !start_read) |=> (m_tvalid && state == S_IDLE))
    else $error("single-cycle command gave no result");

  a_read_holds_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("count changed during read-out");

endmodule

// File: tb/indexed_sequence_buffer_tb.sv
// indexed_sequence_buffer_tb: directed and random command streams on the sequence buffer,
// every result checked field by field against a behavioural model held in the bench
// depends on isb_pkg and indexed_sequence_buffer
module indexed_sequence_buffer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_DEPTH   = 64;
  localparam int ELEM_W      = 32;
  localparam int TAIL_CYCLES = 100;

  localparam logic [isb_pkg::OP_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [isb_pkg::OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  localparam int RV_LO  = 0;
  localparam int ST_LO  = isb_pkg::VALUE_BITS;
  localparam int CNT_LO = isb_pkg::VALUE_BITS + isb_pkg::STATUS_BITS;

  typedef enum int {
    PH_GROW,
    PH_MIX,
    PH_SHRINK
  } phase_t;

  typedef struct {
    logic [isb_pkg::OP_BITS-1:0]    op;
    logic [isb_pkg::INDEX_BITS-1:0] index;
    logic [isb_pkg::VALUE_BITS-1:0] value;
    bit                             drain_first;
  } cmd_t;

  typedef struct {
    logic [isb_pkg::VALUE_BITS-1:0] read_value;
    isb_pkg::status_t               status;
    logic [isb_pkg::COUNT_BITS-1:0] count;
  } res_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [isb_pkg::IN_TDATA-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [isb_pkg::OUT_TDATA-1:0] m_tdata;

  // behavioural copy of the sequence
  logic [ELEM_W-1:0] seq_mem [SEQ_DEPTH];
  int                seq_len;

  cmd_t pending_q[$];
  res_t expected_q[$];

  cmd_t cur_cmd;
  int   send_gap;
  bit   send_steady;
  int   recv_gap;
  bit   recv_steady;

  int err_count;
  int results_seen;
  int op_seen [8];
  int full_rejects;
  int range_rejects;
  int peak_len;

  indexed_sequence_buffer #(
    .DEPTH    (SEQ_DEPTH),
    .ELEM_BITS(ELEM_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t apply_op(cmd_t c);
    res_t r;
    int   n;
    int   idx;
    r.read_value = '0;
    r.status     = isb_pkg::STAT_OK;
    n            = seq_len;
    idx          = int'(c.index);
    case (c.op)
      isb_pkg::OP_APPEND: begin
        if (n >= SEQ_DEPTH) begin
          r.status = isb_pkg::STAT_FULL;
        end else begin
          seq_mem[n] = c.value;
          seq_len    = n + 1;
        end
      end
      isb_pkg::OP_POP: begin
        if (n == 0) begin
          r.status = isb_pkg::STAT_RANGE;
        end else begin
          r.read_value = seq_mem[n-1];
          seq_len      = n - 1;
        end
      end
      isb_pkg::OP_GET: begin
        if (idx >= n) r.status = isb_pkg::STAT_RANGE;
        else r.read_value = seq_mem[idx];
      end
      isb_pkg::OP_SET: begin
        if (idx >= n) r.status = isb_pkg::STAT_RANGE;
        else seq_mem[idx] = c.value;
      end
      isb_pkg::OP_ERASE: begin
        if (idx >= n) begin
          r.status = isb_pkg::STAT_RANGE;
        end else begin
          for (int i = idx; i < n - 1; i++) seq_mem[i] = seq_mem[i+1];
          seq_len = n - 1;
        end
      end
      isb_pkg::OP_INSERT: begin
        // index equal to the length means the end, checked before fullness
        if (idx > n) begin
          r.status = isb_pkg::STAT_RANGE;
        end else if (n >= SEQ_DEPTH) begin
          r.status = isb_pkg::STAT_FULL;
        end else begin
          for (int i = n; i > idx; i--) seq_mem[i] = seq_mem[i-1];
          seq_mem[idx] = c.value;
          seq_len      = n + 1;
        end
      end
      default: ;
    endcase
    r.count = isb_pkg::COUNT_BITS'(seq_len);
    return r;
  endfunction

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_cmd(logic [isb_pkg::OP_BITS-1:0] op, int idx,
                           logic [isb_pkg::VALUE_BITS-1:0] val, bit drain_first);
    cmd_t c;
    c.op          = op;
    c.index       = isb_pkg::INDEX_BITS'(idx);
    c.value       = val;
    c.drain_first = drain_first;
    pending_q.push_back(c);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at result %0d: got %0h, expected %0h",
             field, results_seen, got, want);
    err_count++;
  endtask

  // command side
  always @(posedge clk) begin
    res_t want;
    bit   next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        want = apply_op(cur_cmd);
        expected_q.push_back(want);
        op_seen[cur_cmd.op]++;
        if (want.status == isb_pkg::STAT_FULL) full_rejects++;
        if (want.status == isb_pkg::STAT_RANGE) range_rejects++;
        if (seq_len > peak_len) peak_len = seq_len;
        next_valid = 1'b0;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain_first && expected_q.size() != 0)) begin
          cur_cmd = pending_q.pop_front();
          s_tdata <= {{(isb_pkg::IN_TDATA-isb_pkg::IN_BITS){1'b0}},
                      cur_cmd.value, cur_cmd.index, cur_cmd.op};
          next_valid = 1'b1;
          if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
          send_gap = pick_gap(send_steady);
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // result side
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.read_value = m_tdata[RV_LO +: isb_pkg::VALUE_BITS];
        got.status     = isb_pkg::status_t'(m_tdata[ST_LO +: isb_pkg::STATUS_BITS]);
        got.count      = m_tdata[CNT_LO +: isb_pkg::COUNT_BITS];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer", got.read_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.count !== want.count)
            report_mismatch("count", 32'(got.count), 32'(want.count));
        end
        results_seen++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 199) == 0) recv_steady = !recv_steady;
        if (!recv_steady && $urandom_range(0, 2) == 0) recv_gap = pick_gap(1'b0);
      end
    end
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int                             phase_len [6];
    phase_t                         phase_kind [6];
    isb_pkg::op_t                   op_order [6];
    int                             lim [6];
    int                             r;
    int                             n;
    int                             idx;
    logic [isb_pkg::OP_BITS-1:0]    op;
    logic [isb_pkg::VALUE_BITS-1:0] val;
    bit                             drain;

    phase_len  = '{100, 100, 120, 150, 80, 150};
    phase_kind = '{PH_GROW, PH_MIX, PH_SHRINK, PH_GROW, PH_MIX, PH_SHRINK};
    op_order   = '{isb_pkg::OP_APPEND, isb_pkg::OP_INSERT, isb_pkg::OP_GET,
                   isb_pkg::OP_SET, isb_pkg::OP_ERASE, isb_pkg::OP_POP};
    seq_len    = 0;
    err_count  = 0;
    peak_len   = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty-sequence rejects, inserts at the end and in the middle, boundaries
    queue_cmd(isb_pkg::OP_GET,     0, '0, 1'b0);
    queue_cmd(isb_pkg::OP_POP,     0, '0, 1'b0);
    queue_cmd(isb_pkg::OP_SET,     0, 32'h1111_1111, 1'b0);
    queue_cmd(isb_pkg::OP_ERASE,   0, '0, 1'b0);
    queue_cmd(isb_pkg::OP_INSERT,  1, 32'h2222_2222, 1'b0);
    queue_cmd(isb_pkg::OP_INSERT,  0, 32'h1234_5678, 1'b0);
    queue_cmd(isb_pkg::OP_APPEND, 63, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(isb_pkg::OP_APPEND,  0, 32'h0000_0000, 1'b0);
    queue_cmd(isb_pkg::OP_INSERT, 63, 32'h3333_3333, 1'b0);
    queue_cmd(isb_pkg::OP_INSERT,  1, 32'hA5A5_A5A5, 1'b0);
    queue_cmd(isb_pkg::OP_GET,     0, '0, 1'b0);
    queue_cmd(isb_pkg::OP_GET,     3, '0, 1'b0);
    queue_cmd(isb_pkg::OP_GET,    63, '0, 1'b0);
    queue_cmd(isb_pkg::OP_GET,     4, '0, 1'b0);
    queue_cmd(isb_pkg::OP_SET,     2, 32'h5A5A_5A5A, 1'b0);
    queue_cmd(isb_pkg::OP_GET,     2, '0, 1'b0);
    queue_cmd(isb_pkg::OP_ERASE,   0, '0, 1'b0);
    queue_cmd(isb_pkg::OP_ERASE,   2, '0, 1'b0);
    queue_cmd(OP_SPARE_LO,        63, 32'hFFFF_FFFF, 1'b0);
    queue_cmd(OP_SPARE_HI,         0, '0, 1'b0);
    queue_cmd(isb_pkg::OP_INSERT,  2, 32'h0F0F_0F0F, 1'b0);
    repeat (4) queue_cmd(isb_pkg::OP_POP, 0, '0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (phase_kind[p])
        PH_GROW:   lim = '{45, 70, 78, 86, 91, 96};
        PH_SHRINK: lim = '{10, 20, 30, 40, 65, 95};
        default:   lim = '{20, 40, 55, 70, 82, 96};
      endcase
      for (int k = 0; k < phase_len[p]; k++) begin
        while (pending_q.size() >= 2) @(posedge clk);
        r  = $urandom_range(0, 99);
        op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        for (int j = 5; j >= 0; j--)
          if (r < lim[j]) op = op_order[j];
        n = seq_len;
        r = $urandom_range(0, 9);
        if (r == 0) begin
          idx = (n > 63) ? 63 : n;
        end else if (r < 7) begin
          if (op == isb_pkg::OP_INSERT) idx = $urandom_range(0, (n > 63) ? 63 : n);
          else idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
        end else begin
          idx = $urandom_range(0, 63);
        end
        r = $urandom_range(0, 7);
        if (r == 0) val = '1;
        else if (r == 1) val = '0;
        else val = $urandom;
        drain = (k == 0) && (p == 0 || p == 3);
        queue_cmd(op, idx, val, drain);
      end
    end

    while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d results: append %0d pop %0d get %0d set %0d erase %0d insert %0d spare %0d",
             results_seen, op_seen[isb_pkg::OP_APPEND], op_seen[isb_pkg::OP_POP],
             op_seen[isb_pkg::OP_GET], op_seen[isb_pkg::OP_SET],
             op_seen[isb_pkg::OP_ERASE], op_seen[isb_pkg::OP_INSERT],
             op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI]);
    $display("peak length %0d, full rejects %0d, range rejects %0d, mismatches %0d",
             peak_len, full_rejects, range_rejects, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
